>>> design/insertion_sorter_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the insertion sorter core
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef INSERTION_SORTER_CORE_DEFINES_SVH
`define INSERTION_SORTER_CORE_DEFINES_SVH

// The condition must never hold.
`define ISC_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/isc_pkg.sv
// ---------------------------------------------------------------------------
// isc_pkg
// Shared record and control types for the insertion sorter chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isc_pkg;

    localparam int KEY_W  = 32;
    localparam int TAG_W  = 16;
    localparam int DATA_W = KEY_W + TAG_W;

    // One stored record as held by a cell.
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
    } isc_rec_t;

    // Broadcast control from the top level to every cell.
    typedef struct packed {
        logic insert;   // place the incoming record into the chain
        logic advance;  // move every record one place towards cell 0
    } isc_ctl_t;

endpackage

`default_nettype wire

>>> design/isc_cell.sv
// ---------------------------------------------------------------------------
// isc_cell
// One place of the sorted chain: holds a record and trades with neighbours.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isc_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire isc_pkg::isc_ctl_t ctl,
    input  wire isc_pkg::isc_rec_t new_rec,
    input  wire isc_pkg::isc_rec_t lower_rec,
    input  wire logic              lower_gt,
    input  wire isc_pkg::isc_rec_t upper_rec,
    output isc_pkg::isc_rec_t      rec,
    output logic                   gt
);
    import isc_pkg::*;

    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [TAG_W-1:0] tag_reg, tag_next;
    logic             load;

    // A stored key strictly greater than the new one yields its place,
    // so equal keys keep arrival order.
    assign gt   = valid_reg && ($signed(key_reg) > $signed(new_rec.key));
    assign load = gt || (!valid_reg && lower_rec.valid);

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        if (ctl.advance)
        begin
            valid_next = upper_rec.valid;
            key_next   = upper_rec.key;
            tag_next   = upper_rec.tag;
        end
        else if (ctl.insert)
        begin
            if (lower_gt)
            begin
                valid_next = lower_rec.valid;
                key_next   = lower_rec.key;
                tag_next   = lower_rec.tag;
            end
            else if (load)
            begin
                valid_next = 1'b1;
                key_next   = new_rec.key;
                tag_next   = new_rec.tag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign rec.valid = valid_reg;
    assign rec.key   = key_reg;
    assign rec.tag   = tag_reg;

endmodule

`default_nettype wire

>>> design/insertion_sorter_core.sv
// ---------------------------------------------------------------------------
// insertion_sorter_core
// Stable insertion sorter built as a chain of compare-and-shift cells.
// ---------------------------------------------------------------------------
// Records enter on the s_ channel, one item per cycle while loading: every
// cell compares its key with the incoming one at once, and larger keys move
// up one place in the same cycle as the new item is written into the chain.
// An item with s_tlast high closes the set and is stored too unless the
// store is full; s_tready then drops and the chain drains from cell 0 onto
// the m_ channel, one item per cycle while m_tready is high, ascending by
// key, with m_tlast on the largest key. The first result appears the cycle
// after the closing item is accepted. The drain rate is set by the single
// shift step of the chain per cycle. Items arriving while all CAPACITY
// cells are full are dropped, and m_tuser is then high on every result of
// that set. A stall on m_tready simply holds cell 0 and the whole chain.
// After the last result is taken the block is empty and s_tready returns
// high. Reset empties every cell and clears the drop flag; no clearing
// pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "insertion_sorter_core_defines.svh"

module insertion_sorter_core #(
    parameter int CAPACITY = 64
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // Input channel. s_tdata fields from bit 0: key[31:0], tag[47:32].
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [isc_pkg::DATA_W-1:0] s_tdata,
    input  wire logic                       s_tlast,   // final_item
    // Output channel. m_tdata fields from bit 0: sorted_key[31:0],
    // sorted_tag[47:32].
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [isc_pkg::DATA_W-1:0]      m_tdata,
    output logic                            m_tlast,   // end_of_set
    output logic                            m_tuser    // overflowed
);
    import isc_pkg::*;

    isc_rec_t recs [CAPACITY];
    logic     gts  [CAPACITY];
    isc_rec_t new_rec;
    isc_rec_t edge_lo;
    isc_rec_t edge_hi;
    isc_ctl_t ctl;

    logic draining_reg, draining_next;
    logic drop_reg, drop_next;
    logic s_acc, m_acc, full;

    assign new_rec.valid = 1'b1;
    assign new_rec.key   = s_tdata[KEY_W-1:0];
    assign new_rec.tag   = s_tdata[DATA_W-1:KEY_W];

    // Below cell 0 sits a virtual filled cell that never yields its place;
    // above the last cell sits an empty one that feeds the drain.
    assign edge_lo = '{valid: 1'b1, key: '0, tag: '0};
    assign edge_hi = '{valid: 1'b0, key: '0, tag: '0};

    // The store is full when the top cell holds a record.
    assign full = recs[CAPACITY-1].valid;

    assign s_tready = !draining_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = draining_reg && recs[0].valid;
    assign m_acc    = m_tvalid && m_tready;

    assign ctl.insert  = s_acc && !full;
    assign ctl.advance = m_acc;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            isc_rec_t lo_rec;
            isc_rec_t hi_rec;
            logic     lo_gt;

            if (i == 0)
            begin : g_bottom
                assign lo_rec = edge_lo;
                assign lo_gt  = 1'b0;
            end
            else
            begin : g_mid_lo
                assign lo_rec = recs[i-1];
                assign lo_gt  = gts[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_top
                assign hi_rec = edge_hi;
            end
            else
            begin : g_mid_hi
                assign hi_rec = recs[i+1];
            end

            isc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .new_rec   (new_rec),
                .lower_rec (lo_rec),
                .lower_gt  (lo_gt),
                .upper_rec (hi_rec),
                .rec       (recs[i]),
                .gt        (gts[i])
            );
        end
    endgenerate

    // Cell 0 is the output register; the set ends where cell 1 is empty.
    assign m_tdata = {recs[0].tag, recs[0].key};
    assign m_tlast = recs[0].valid && !recs[1].valid;
    assign m_tuser = drop_reg;

    always_comb
    begin
        draining_next = draining_reg;
        drop_next     = drop_reg;
        if (m_acc && m_tlast)
        begin
            draining_next = 1'b0;
            drop_next     = 1'b0;
        end
        else if (s_acc)
        begin
            if (s_tlast)
            begin
                draining_next = 1'b1;
            end
            if (full)
            begin
                drop_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            draining_reg <= 1'b0;
            drop_reg     <= 1'b0;
        end
        else
        begin
            draining_reg <= draining_next;
            drop_reg     <= drop_next;
        end
    end

    // Loading and draining never overlap.
    `ISC_ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid, "input ready while draining")

    // Results of a set come out in non-descending key order without gaps.
    `ISC_ASSERT_NEXT(a_ascending, m_acc && !m_tlast,
        m_tvalid && ($signed(m_tdata[KEY_W-1:0]) >= $signed($past(m_tdata[KEY_W-1:0]))),
        "drain order broken")

    // After the final result the block is empty and ready for a new set.
    `ISC_ASSERT_NEXT(a_cleared, m_acc && m_tlast,
        s_tready && !m_tuser && !recs[0].valid, "block not cleared after set")

endmodule

`default_nettype wire

>>> sim/tb_insertion_sorter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_insertion_sorter_core
// Self-checking bench for the stable insertion sorter core.
// ---------------------------------------------------------------------------
// Records are sent as sets closed by an item with s_tlast high. A predictor
// keeps its own sorted store of the open set and, when a set closes, queues
// the ranked results it should produce. Every result taken from the master
// side is compared field by field with the oldest queued one. Both sides
// idle and stall at random, with calm stretches in between.
// ---------------------------------------------------------------------------

module tb_insertion_sorter_core;

    localparam int CAPACITY    = 64;
    localparam int KEY_W       = isc_pkg::KEY_W;
    localparam int TAG_W       = isc_pkg::TAG_W;
    localparam int DATA_W      = isc_pkg::DATA_W;
    localparam int ITEM_TARGET = 420;

    typedef enum int {KEYS_WIDE, KEYS_NARROW, KEYS_EDGE} key_mode_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } record_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
        logic             end_of_set;
        logic             overflowed;
    } ranked_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    // Predictor state: the open set in sorted order and the drop marker.
    record_t held_records[$];
    logic    drop_seen;
    // Ranked results still to come out of the block.
    ranked_t due_results[$];

    int items_sent;
    int fail_count;
    bit sender_calm;
    bit sink_calm;

    insertion_sorter_core #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stable insertion: a new record goes after every stored record whose key
    // is not larger. A full store drops the record, the closing one included.
    function automatic void absorb_record(input logic [KEY_W-1:0] k,
                                          input logic [TAG_W-1:0] t,
                                          input logic last);
        int      pos;
        record_t rec;
        ranked_t res;
        rec.key = k;
        rec.tag = t;
        if (held_records.size() >= CAPACITY)
        begin
            drop_seen = 1'b1;
        end
        else
        begin
            pos = held_records.size();
            while (pos > 0 && $signed(held_records[pos-1].key) > $signed(k))
                pos--;
            held_records.insert(pos, rec);
        end
        if (last)
        begin
            foreach (held_records[i])
            begin
                res.key        = held_records[i].key;
                res.tag        = held_records[i].tag;
                res.end_of_set = (i == held_records.size() - 1);
                res.overflowed = drop_seen;
                due_results.push_back(res);
            end
            held_records.delete();
            drop_seen = 1'b0;
        end
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_calm || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input key_mode_t mode);
        int v;
        case (mode)
            KEYS_NARROW:
            begin
                // A handful of values close to zero, so ties are frequent.
                v = $urandom_range(0, 6);
                return KEY_W'(v - 3);
            end
            KEYS_EDGE:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h8000_0001;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Presents one item and returns at the edge where it was accepted. The
    // valid line is left high so that a following item can go out at once.
    task automatic send_record(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                               input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t, k};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        absorb_record(k, t, last);
        items_sent++;
    endtask

    task automatic send_set(input int n, input key_mode_t mode);
        for (int i = 0; i < n; i++)
            send_record(pick_key(mode), TAG_W'($urandom()), i == n - 1);
    endtask

    // Holds the sender back until every queued result has come out.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (due_results.size() != 0);
    endtask

    // A set of one record, closed straight away.
    task automatic test_lone_final();
        send_record(32'h8000_0000, 16'hFFFF, 1'b1);
        wait_for_results();
    endtask

    // Extreme keys, mostly in falling order, so most records shift the whole store.
    task automatic test_key_extremes();
        send_record(32'h7FFF_FFFF, 16'h0000, 1'b0);
        send_record(32'h0000_0001, 16'hFFFF, 1'b0);
        send_record(32'h0000_0000, 16'h5555, 1'b0);
        send_record(32'hFFFF_FFFF, 16'hAAAA, 1'b0);
        send_record(32'h8000_0001, 16'h0001, 1'b0);
        send_record(32'h8000_0000, 16'h8000, 1'b0);
        send_record(32'h7FFF_FFFE, 16'h7FFF, 1'b1);
        wait_for_results();
    endtask

    // Equal keys must leave in arrival order; the tags tell them apart.
    task automatic test_equal_keys();
        send_record(32'd5,         16'd1, 1'b0);
        send_record(32'd5,         16'd2, 1'b0);
        send_record(-32'sd3,       16'd3, 1'b0);
        send_record(32'd5,         16'd4, 1'b0);
        send_record(-32'sd3,       16'd5, 1'b0);
        send_record(32'h7FFF_FFFF, 16'd6, 1'b0);
        send_record(32'h7FFF_FFFF, 16'd7, 1'b0);
        send_record(32'd5,         16'd8, 1'b1);
        wait_for_results();
    endtask

    // Already ascending input: no record ever moves.
    task automatic test_presorted();
        send_record(-32'sd100, 16'h0010, 1'b0);
        send_record(-32'sd1,   16'h0020, 1'b0);
        send_record(32'd0,     16'h0030, 1'b0);
        send_record(32'd1000,  16'h0040, 1'b1);
        wait_for_results();
    endtask

    // An exactly full set, then sets that overrun the store; in the second
    // one only the closing record is dropped.
    task automatic test_store_full();
        send_set(CAPACITY, KEYS_WIDE);
        send_set(CAPACITY + 1, KEYS_NARROW);
        wait_for_results();
        send_set(CAPACITY + $urandom_range(2, 6), KEYS_EDGE);
    endtask

    task automatic test_random_sets();
        int        n;
        int        roll;
        key_mode_t mode;
        while (items_sent < ITEM_TARGET)
        begin
            roll = $urandom_range(0, 99);
            n = (roll < 75) ? $urandom_range(1, 10) : $urandom_range(11, 40);
            roll = $urandom_range(0, 99);
            if (roll < 50)
                mode = KEYS_WIDE;
            else if (roll < 80)
                mode = KEYS_NARROW;
            else
                mode = KEYS_EDGE;
            sender_calm = ($urandom_range(0, 4) == 0);
            sink_calm   = ($urandom_range(0, 4) == 0);
            send_set(n, mode);
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
        end
        sender_calm = 1'b0;
        sink_calm   = 1'b0;
    endtask

    // Receiver back-pressure: ready in short runs at a time, with short
    // stalls and now and then a long one.
    initial
    begin : sink_stalls
        int hold;
        int roll;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            roll = $urandom_range(0, 99);
            if (sink_calm || roll < 65)
            begin
                m_tready <= 1'b1;
                hold = $urandom_range(1, 8);
            end
            else if (roll < 95)
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(1, 3);
            end
            else
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(10, 40);
            end
            repeat (hold) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_results
        ranked_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: result expected none got key %0d tag %0d", $time,
                         $signed(m_tdata[KEY_W-1:0]), m_tdata[DATA_W-1:KEY_W]);
            end
            else
            begin
                want = due_results.pop_front();
                if (m_tdata[KEY_W-1:0] !== want.key)
                begin
                    fail_count++;
                    $display("%0t: sorted_key expected %0d got %0d", $time,
                             $signed(want.key), $signed(m_tdata[KEY_W-1:0]));
                end
                if (m_tdata[DATA_W-1:KEY_W] !== want.tag)
                begin
                    fail_count++;
                    $display("%0t: sorted_tag expected %0d got %0d", $time,
                             want.tag, m_tdata[DATA_W-1:KEY_W]);
                end
                if (m_tlast !== want.end_of_set)
                begin
                    fail_count++;
                    $display("%0t: end_of_set expected %0b got %0b", $time,
                             want.end_of_set, m_tlast);
                end
                if (m_tuser !== want.overflowed)
                begin
                    fail_count++;
                    $display("%0t: overflowed expected %0b got %0b", $time,
                             want.overflowed, m_tuser);
                end
            end
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        drop_seen   = 1'b0;
        items_sent  = 0;
        fail_count  = 0;
        sender_calm = 1'b0;
        sink_calm   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_lone_final();
        test_key_extremes();
        test_equal_keys();
        test_presorted();
        test_store_full();
        test_random_sets();

        wait_for_results();
        repeat (CAPACITY + 8) @(posedge clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Far beyond the slowest correct run: every item its longest gap and
    // every result its longest stall.
    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
